[design/mlqs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlqs_pkg
// Shared types, codes and helpers of the multilevel queue scheduler: request
// and response payloads, the slot record kept in memory and the sequencer
// states.
// ----------------------------------------------------------------------------
package mlqs_pkg;

   // Default table depth
   localparam int MAX_SLOTS_DEF = 16;

   // Time is a saturating 21-bit tick count
   localparam int          TIME_W   = 21;
   localparam logic [20:0] TIME_MAX = 21'h1FFFFF;

   // Request kinds
   localparam logic [1:0] KIND_LOAD  = 2'd0;
   localparam logic [1:0] KIND_TICK  = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  slot;
      logic [15:0] arrival;
      logic [15:0] burst;
      logic        is_user;
   } req_item_type;

   typedef struct packed {
      logic [20:0] now;
      logic        busy_res;
      logic [3:0]  running_slot;
      logic        from_user;
      logic        switched;
      logic        finished;
      logic [20:0] turnaround;
      logic [20:0] waiting;
      logic [20:0] response;
      logic        all_done;
   } rsp_item_type;

   // One task slot as kept in the slot memory
   typedef struct packed {
      logic [15:0] arrival;
      logic [15:0] burst;
      logic [15:0] remaining;
      logic        is_user;
      logic [20:0] first_run;
   } slot_rec_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_APPLY,
      ST_FINISH
   } state_type;

   // Advance a time value by one tick, holding at the top
   function automatic logic [20:0] time_inc(input logic [20:0] t);
      logic [20:0] r;
      r = (t == TIME_MAX) ? TIME_MAX : t + 21'd1;
      return r;
   endfunction

endpackage

[design/multilevel_queue_scheduler.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multilevel_queue_scheduler
// Two-level fixed-priority task scheduler. System slots run in slot index order,
// user slots by shortest remaining time. Slot records live in one
// synchronous memory that each tick scans, then updates in place.
//
//   channel  dir  handshake            payload
//   req      in   req_valid/req_stall  req_data  (load, tick or clear)
//   rsp      out  rsp_valid/rsp_stall  rsp_data  (one per tick request)
//
// A load or clear request completes as it is taken. A tick holds req_stall
// through the scan, apply and finish states: one memory read per slot
// through the single read port, a check of the last slot and the exit from
// the scan, one read-modify-write and the forming of the result. The result
// becomes valid as the sequencer returns to idle, so the next request can be
// taken in that same cycle.
// The result sits in an output register, so the next request is taken while
// it waits; a tick that finishes while that register is still held waits
// for it. Reset is synchronous and empties the table without touching the
// memory: per-slot live and started bits gate every entry.
// ----------------------------------------------------------------------------
module multilevel_queue_scheduler
   import mlqs_pkg::*;
#(
   parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_data
);

   localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam logic [SW:0] NO_SLOT = (SW + 1)'(MAX_SLOTS);

   // Slot memory
   slot_rec_type slot_mem [MAX_SLOTS];
   slot_rec_type rd_data_ff;
   logic         rd_en;
   logic [SW-1:0] rd_addr;
   logic         mem_we;
   logic [SW-1:0] mem_waddr;
   slot_rec_type mem_wdata;

   // Control and scan state
   state_type        state_ff, state_in;
   logic [20:0]      clock_ff, clock_in;
   logic [SW:0]      last_run_ff, last_run_in;
   logic [MAX_SLOTS-1:0] live_ff, live_in;
   logic [MAX_SLOTS-1:0] started_ff, started_in;
   logic [SW:0]      scan_cnt_ff, scan_cnt_in;
   logic             data_vld_ff, data_vld_in;
   logic [SW-1:0]    data_idx_ff, data_idx_in;
   logic             sys_hit_ff, sys_hit_in;
   logic [SW-1:0]    sys_idx_ff, sys_idx_in;
   slot_rec_type     sys_rec_ff, sys_rec_in;
   logic             usr_hit_ff, usr_hit_in;
   logic [SW-1:0]    usr_idx_ff, usr_idx_in;
   slot_rec_type     usr_rec_ff, usr_rec_in;
   rsp_item_type     res_ff, res_in;
   logic [15:0]      burst_hold_ff, burst_hold_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_item_type     rsp_data_ff, rsp_data_in;

   // Working values
   logic          req_take;
   logic [6:0]    slot_x;
   logic          slot_ok;
   logic          issue;
   logic          ready;
   logic          pick_hit;
   logic [SW-1:0] pick_idx;
   slot_rec_type  pick_rec;
   logic [20:0]   first_time;
   logic [15:0]   rem_dec;
   logic [20:0]   done_time;
   logic          out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign slot_x  = 7'(req_data.slot);
   assign slot_ok = (slot_x < 7'(MAX_SLOTS));
   assign issue   = (scan_cnt_ff < (SW + 1)'(MAX_SLOTS));
   assign ready   = live_ff[data_idx_ff] && ({5'd0, rd_data_ff.arrival} <= clock_ff);

   // Pick: system slot wins, else best user slot
   assign pick_hit   = sys_hit_ff || usr_hit_ff;
   assign pick_idx   = sys_hit_ff ? sys_idx_ff : usr_idx_ff;
   assign pick_rec   = sys_hit_ff ? sys_rec_ff : usr_rec_ff;
   assign first_time = started_ff[pick_idx] ? pick_rec.first_run : clock_ff;
   assign rem_dec    = pick_rec.remaining - 16'd1;
   assign done_time  = time_inc(clock_ff);

   // Next state, memory access and result formation
   always_comb begin
      state_in      = state_ff;
      clock_in      = clock_ff;
      last_run_in   = last_run_ff;
      live_in       = live_ff;
      started_in    = started_ff;
      scan_cnt_in   = scan_cnt_ff;
      data_vld_in   = 1'b0;
      data_idx_in   = data_idx_ff;
      sys_hit_in    = sys_hit_ff;
      sys_idx_in    = sys_idx_ff;
      sys_rec_in    = sys_rec_ff;
      usr_hit_in    = usr_hit_ff;
      usr_idx_in    = usr_idx_ff;
      usr_rec_in    = usr_rec_ff;
      res_in        = res_ff;
      burst_hold_in = burst_hold_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      rd_en         = 1'b0;
      rd_addr       = scan_cnt_ff[SW-1:0];
      mem_we        = 1'b0;
      mem_waddr     = slot_x[SW-1:0];
      mem_wdata     = '{arrival: req_data.arrival, burst: req_data.burst,
                        remaining: req_data.burst, is_user: req_data.is_user,
                        first_run: 21'd0};

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               case (req_data.kind)
                  KIND_LOAD: begin
                     // Overwrite the slot and restart its progress
                     if (slot_ok) begin
                        mem_we                      = 1'b1;
                        live_in[slot_x[SW-1:0]]    = (req_data.burst != 16'd0);
                        started_in[slot_x[SW-1:0]] = 1'b0;
                     end
                  end
                  KIND_TICK: begin
                     scan_cnt_in = '0;
                     sys_hit_in  = 1'b0;
                     usr_hit_in  = 1'b0;
                     state_in    = ST_SCAN;
                  end
                  KIND_CLEAR: begin
                     live_in     = '0;
                     started_in  = '0;
                     clock_in    = 21'd0;
                     last_run_in = NO_SLOT;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_SCAN: begin
            // Issue one read per slot
            if (issue) begin
               rd_en       = 1'b1;
               data_vld_in = 1'b1;
               data_idx_in = scan_cnt_ff[SW-1:0];
               scan_cnt_in = scan_cnt_ff + 1'b1;
            end
            // Check the slot read in the previous cycle
            if (data_vld_ff && ready) begin
               if (!rd_data_ff.is_user && !sys_hit_ff) begin
                  sys_hit_in = 1'b1;
                  sys_idx_in = data_idx_ff;
                  sys_rec_in = rd_data_ff;
               end
               if (rd_data_ff.is_user &&
                   (!usr_hit_ff || rd_data_ff.remaining < usr_rec_ff.remaining)) begin
                  usr_hit_in = 1'b1;
                  usr_idx_in = data_idx_ff;
                  usr_rec_in = rd_data_ff;
               end
            end
            if (!issue && !data_vld_ff) begin
               state_in = ST_APPLY;
            end
         end

         ST_APPLY: begin
            // Run the picked slot and write it back
            res_in              = '0;
            res_in.now          = clock_ff;
            burst_hold_in       = pick_rec.burst;
            if (pick_hit) begin
               res_in.busy_res     = 1'b1;
               res_in.running_slot = 4'(pick_idx);
               res_in.from_user    = !sys_hit_ff;
               res_in.switched     = (last_run_ff != {1'b0, pick_idx});
               last_run_in         = {1'b0, pick_idx};
               started_in[pick_idx] = 1'b1;
               live_in[pick_idx]    = (rem_dec != 16'd0);
               mem_we              = 1'b1;
               mem_waddr           = pick_idx;
               mem_wdata           = pick_rec;
               mem_wdata.remaining = rem_dec;
               mem_wdata.first_run = first_time;
               if (rem_dec == 16'd0) begin
                  res_in.finished   = 1'b1;
                  res_in.turnaround = done_time - {5'd0, pick_rec.arrival};
                  res_in.response   = first_time - {5'd0, pick_rec.arrival};
               end
            end
            clock_in = done_time;
            state_in = ST_FINISH;
         end

         ST_FINISH: begin
            // Clamp waiting, then hand the result to the output register
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in          = res_ff;
               rsp_data_in.all_done = (live_ff == '0);
               if (res_ff.finished && res_ff.turnaround >= {5'd0, burst_hold_ff}) begin
                  rsp_data_in.waiting = res_ff.turnaround - {5'd0, burst_hold_ff};
               end else begin
                  rsp_data_in.waiting = 21'd0;
               end
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Slot memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= slot_mem[rd_addr];
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         clock_ff     <= 21'd0;
         last_run_ff  <= NO_SLOT;
         live_ff      <= '0;
         started_ff   <= '0;
         scan_cnt_ff  <= '0;
         data_vld_ff  <= 1'b0;
         sys_hit_ff   <= 1'b0;
         usr_hit_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clock_ff     <= clock_in;
         last_run_ff  <= last_run_in;
         live_ff      <= live_in;
         started_ff   <= started_in;
         scan_cnt_ff  <= scan_cnt_in;
         data_vld_ff  <= data_vld_in;
         sys_hit_ff   <= sys_hit_in;
         usr_hit_ff   <= usr_hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      data_idx_ff   <= data_idx_in;
      sys_idx_ff    <= sys_idx_in;
      sys_rec_ff    <= sys_rec_in;
      usr_idx_ff    <= usr_idx_in;
      usr_rec_ff    <= usr_rec_in;
      res_ff        <= res_in;
      burst_hold_ff <= burst_hold_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // A captured system pick never comes from the user queue
   a_sys_pick_queue: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_APPLY && sys_hit_ff) |-> !sys_rec_ff.is_user)
      else $error("system pick holds a user slot");

   // The slot that runs is still live
   a_pick_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_APPLY && pick_hit) |-> live_ff[pick_idx])
      else $error("picked slot has no remaining time");

   // Time never runs backward across a tick
   a_time_mono: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_APPLY) |=> (clock_ff >= $past(clock_ff)))
      else $error("time moved backward");

   // A new result appears only out of the finish step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result issued outside finish step");

   // Scan reads stay inside the table
   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      data_vld_ff |-> ((SW + 1)'(data_idx_ff) < (SW + 1)'(MAX_SLOTS)))
      else $error("scan index beyond table");

endmodule
